// File: sv/ccc_pkg.sv
// Shared constants for the cycle component counter.
package ccc_pkg;
    localparam int unsigned MAX_VERTICES = 1024;
    localparam int unsigned VW           = $clog2(MAX_VERTICES);
    localparam int unsigned CW           = 11;
    localparam logic        CMD_ADD      = 1'b0;
    localparam logic        CMD_FINISH   = 1'b1;
    localparam logic [CW-1:0] VC_RESET   = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] CNT_MAX    = '1;
endpackage

// File: sv/cycle_component_counter.sv
// Top level: union-find cycle component counter with one sequencer.
//
//  channel | signals                         | carries
//  --------+---------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser | edge endpoints, cmd in tuser
//  out     | m_tvalid m_tready m_tdata       | cycle_count, edges_dropped
//  config  | cfg_we cfg_wdata                | vertex_count
//
// Edge word: a degree update per endpoint (one for a self-loop), a root search per
// endpoint, then a link of the roots. Finish word: a pass over all 1024 vertices
// with a root search per vertex of degree other than 2, a root search per vertex
// in 1..vertex_count, then a clearing pass over all 1024. The same pass runs after reset.
// The result waits in an output register; a finish stalls only if it is full.
module cycle_component_counter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // vertex_a[10:0], vertex_b[21:11]
    input  logic                  s_tuser,   // cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // cycle_count[10:0], edges_dropped[11]
    input  logic                  cfg_we,
    input  logic [ccc_pkg::CW-1:0] cfg_wdata
);
    import ccc_pkg::*;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DRA    = 5'd2;
    localparam logic [4:0] S_DWA    = 5'd3;
    localparam logic [4:0] S_DRB    = 5'd4;
    localparam logic [4:0] S_DWB    = 5'd5;
    localparam logic [4:0] S_FA_RD  = 5'd6;
    localparam logic [4:0] S_FCHK   = 5'd7;
    localparam logic [4:0] S_FB_RD  = 5'd8;
    localparam logic [4:0] S_UN     = 5'd9;
    localparam logic [4:0] S_P1_RD  = 5'd10;
    localparam logic [4:0] S_P1_CHK = 5'd11;
    localparam logic [4:0] S_P1_SET = 5'd12;
    localparam logic [4:0] S_P2_RD  = 5'd13;
    localparam logic [4:0] S_P2_SP  = 5'd14;
    localparam logic [4:0] S_P2_CHK = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    localparam logic [VW-1:0] V_LAST = VW'(MAX_VERTICES - 1);

    logic [4:0]    state_reg, state_next, ret_reg, ret_next;
    logic [VW-1:0] v_reg, v_next, cur_reg, cur_next, ra_reg, ra_next;
    logic [VW-1:0] va_reg, va_next, vb_reg, vb_next;
    logic [CW-1:0] vc_reg, cnt_reg, cnt_next, n_eff, in_a, in_b;
    logic          drop_reg, drop_next, ovalid_reg, ovalid_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic          odrop_reg, odrop_next;

    logic          lk_we, dg_we, sp_we, sp_wdata, sp_rdata;
    logic [VW-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
    logic [VW-1:0] dg_waddr, dg_raddr, sp_waddr, sp_raddr;
    logic [1:0]    dg_wdata, dg_rdata;
    logic [2:0]    dg_sum;
    logic          accept, bad_edge;

    ccc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );
    ccc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_deg (
        .clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
        .raddr(dg_raddr), .rdata(dg_rdata)
    );
    ccc_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_spoil (
        .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .rdata(sp_rdata)
    );

    assign n_eff    = (vc_reg > VC_RESET) ? VC_RESET : vc_reg;
    assign in_a     = s_tdata[10:0];
    assign in_b     = s_tdata[21:11];
    assign bad_edge = (in_a == '0) || (in_b == '0) || (in_a > n_eff) || (in_b > n_eff);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'b0, odrop_reg, ocnt_reg};
    assign dg_sum   = {1'b0, dg_rdata} + ((va_reg == vb_reg) ? 3'd2 : 3'd1);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        v_next      = v_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        va_next     = va_reg;
        vb_next     = vb_reg;
        cnt_next    = cnt_reg;
        drop_next   = drop_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ocnt_next   = ocnt_reg;
        odrop_next  = odrop_reg;
        lk_we       = 1'b0;
        lk_waddr    = v_reg;
        lk_wdata    = v_reg;
        lk_raddr    = cur_reg;
        dg_we       = 1'b0;
        dg_waddr    = va_reg;
        dg_wdata    = (dg_sum > 3'd3) ? 2'd3 : dg_sum[1:0];
        dg_raddr    = va_reg;
        sp_we       = 1'b0;
        sp_waddr    = cur_reg;
        sp_wdata    = 1'b1;
        sp_raddr    = cur_reg;
        case (state_reg)
            S_CLR:
            begin
                lk_we    = 1'b1;
                dg_we    = 1'b1;
                dg_waddr = v_reg;
                dg_wdata = 2'd0;
                sp_we    = 1'b1;
                sp_waddr = v_reg;
                sp_wdata = 1'b0;
                v_next   = v_reg + 1'b1;
                if (v_reg == V_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_FINISH)
                    begin
                        v_next     = '0;
                        cnt_next   = '0;
                        state_next = S_P1_RD;
                    end
                    else if (bad_edge)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        va_next    = VW'(in_a - 1'b1);
                        vb_next    = VW'(in_b - 1'b1);
                        state_next = S_DRA;
                    end
                end
            end
            S_DRA:
            begin
                state_next = S_DWA;
            end
            S_DWA:
            begin
                dg_we      = 1'b1;
                state_next = (va_reg == vb_reg) ? S_FA_RD : S_DRB;
            end
            S_DRB:
            begin
                dg_raddr   = vb_reg;
                state_next = S_DWB;
            end
            S_DWB:
            begin
                dg_we      = 1'b1;
                dg_waddr   = vb_reg;
                state_next = S_FA_RD;
            end
            S_FA_RD:
            begin
                lk_raddr   = va_reg;
                cur_next   = va_reg;
                ret_next   = S_FB_RD;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                // follow the parent link until it points at itself
                if (lk_rdata == cur_reg)
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    lk_raddr = lk_rdata;
                    cur_next = lk_rdata;
                end
            end
            S_FB_RD:
            begin
                ra_next    = cur_reg;
                lk_raddr   = vb_reg;
                cur_next   = vb_reg;
                ret_next   = S_UN;
                state_next = S_FCHK;
            end
            S_UN:
            begin
                if (ra_reg != cur_reg)
                begin
                    lk_we = 1'b1;
                    if (ra_reg < cur_reg)
                    begin
                        lk_waddr = cur_reg;
                        lk_wdata = ra_reg;
                    end
                    else
                    begin
                        lk_waddr = ra_reg;
                        lk_wdata = cur_reg;
                    end
                end
                state_next = S_IDLE;
            end
            S_P1_RD:
            begin
                dg_raddr   = v_reg;
                state_next = S_P1_CHK;
            end
            S_P1_CHK:
            begin
                if (dg_rdata != 2'd2)
                begin
                    lk_raddr   = v_reg;
                    cur_next   = v_reg;
                    ret_next   = S_P1_SET;
                    state_next = S_FCHK;
                end
                else if (v_reg == V_LAST)
                begin
                    v_next     = '0;
                    state_next = (n_eff == '0) ? S_OUT : S_P2_RD;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_P1_RD;
                end
            end
            S_P1_SET:
            begin
                sp_we = 1'b1;
                if (v_reg == V_LAST)
                begin
                    v_next     = '0;
                    state_next = (n_eff == '0) ? S_OUT : S_P2_RD;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_P1_RD;
                end
            end
            S_P2_RD:
            begin
                lk_raddr   = v_reg;
                cur_next   = v_reg;
                ret_next   = S_P2_SP;
                state_next = S_FCHK;
            end
            S_P2_SP:
            begin
                state_next = S_P2_CHK;
            end
            S_P2_CHK:
            begin
                if (!sp_rdata)
                begin
                    sp_we = 1'b1;
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if ({1'b0, v_reg} == n_eff - 1'b1)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = S_P2_RD;
                end
            end
            S_OUT:
            begin
                if (!ovalid_next)
                begin
                    ovalid_next = 1'b1;
                    ocnt_next   = cnt_reg;
                    odrop_next  = drop_reg;
                    drop_next   = 1'b0;
                    v_next      = '0;
                    state_next  = S_CLR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            ret_reg    <= S_IDLE;
            v_reg      <= '0;
            vc_reg     <= VC_RESET;
            drop_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            v_reg      <= v_next;
            drop_reg   <= drop_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        ra_reg    <= ra_next;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        cnt_reg   <= cnt_next;
        ocnt_reg  <= ocnt_next;
        odrop_reg <= odrop_next;
    end
endmodule

// File: sv/ccc_ram.sv
// Generic single write, single read RAM with registered read data.
module ccc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/ccc_checker.sv
// Port-level checker for the cycle component counter, bound to the top level.
module ccc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import ccc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_busy_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_FINISH) |=> !s_tready)
        else $error("input ready right after a finish word");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:0] <= 11'd1024)
        else $error("cycle count above vertex limit");

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while input was ready");
endmodule

bind cycle_component_counter ccc_checker u_ccc_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: sim/testbench.sv
// Self-checking testbench for cycle_component_counter.
module testbench;
    import ccc_pkg::*;

    typedef struct packed {
        logic [CW-1:0] cycle_count;
        logic          edges_dropped;
    } report_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [23:0]   s_tdata = '0;
    logic          s_tuser = CMD_ADD;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [15:0]   m_tdata;
    logic          cfg_we = 1'b0;
    logic [CW-1:0] cfg_wdata = '0;

    cycle_component_counter dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    int unsigned graph_vertices;
    int unsigned parent_link [MAX_VERTICES];
    int unsigned degree_of [MAX_VERTICES];
    bit          spoiled [MAX_VERTICES];
    bit          any_dropped;
    report_t     expected_reports [$];
    int unsigned mismatches = 0;
    bit          rx_stall_on = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("FAIL cycle_component_counter");
        $finish;
    end

    function automatic void clear_graph();
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            parent_link[v] = v;
            degree_of[v] = 0;
            spoiled[v] = 1'b0;
        end
        any_dropped = 1'b0;
    endfunction

    function automatic int unsigned root_of(int unsigned v);
        int unsigned guard;
        int unsigned up;
        guard = 0;
        v = v % MAX_VERTICES;
        while (parent_link[v] != v && guard < MAX_VERTICES)
        begin
            up = parent_link[v] % MAX_VERTICES;
            parent_link[v] = parent_link[up] % MAX_VERTICES;
            v = parent_link[v];
            guard++;
        end
        return v;
    endfunction

    function automatic void bump_degree(int unsigned v, int unsigned amount);
        degree_of[v] = (degree_of[v] + amount > 3) ? 3 : degree_of[v] + amount;
    endfunction

    function automatic void predict_word(logic cmd, logic [10:0] a, logic [10:0] b);
        int unsigned n;
        int unsigned ra;
        int unsigned rb;
        int unsigned cnt;
        report_t rep;
        n = (graph_vertices > MAX_VERTICES) ? MAX_VERTICES : graph_vertices;
        if (cmd == CMD_ADD)
        begin
            if (a == 0 || b == 0 || a > n || b > n)
            begin
                any_dropped = 1'b1;
                return;
            end
            if (a == b)
                bump_degree(a - 1, 2);
            else
            begin
                bump_degree(a - 1, 1);
                bump_degree(b - 1, 1);
            end
            ra = root_of(a - 1);
            rb = root_of(b - 1);
            if (ra < rb)
                parent_link[rb] = ra;
            else if (rb < ra)
                parent_link[ra] = rb;
            return;
        end
        cnt = 0;
        for (int v = 0; v < MAX_VERTICES; v++)
            if (degree_of[v] != 2)
                spoiled[root_of(v)] = 1'b1;
        for (int v = 0; v < n; v++)
        begin
            ra = root_of(v);
            if (!spoiled[ra])
            begin
                spoiled[ra] = 1'b1;
                if (cnt < 2047)
                    cnt++;
            end
        end
        rep.cycle_count = cnt[CW-1:0];
        rep.edges_dropped = any_dropped;
        expected_reports = {expected_reports, rep};
        clear_graph();
    endfunction

    // returns at the accepting rising edge; the next call or wait_idle withdraws the word
    task automatic send_word(logic cmd, logic [10:0] a, logic [10:0] b, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, b, a};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_word(cmd, a, b);
    endtask

    task automatic add_edge(int unsigned a, int unsigned b);
        send_word(CMD_ADD, a[10:0], b[10:0]);
    endtask

    task automatic finish_graph();
        send_word(CMD_FINISH, 11'($urandom()), 11'($urandom()));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge clk);
        repeat (3000) @(negedge clk);
    endtask

    task automatic set_vertices(int unsigned n);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= n[CW-1:0];
        graph_vertices = n & 11'h7FF;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ring of length len starting at base
    task automatic add_ring(int unsigned base, int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            add_edge(base + i, base + (i + 1) % len);
    endtask

    task automatic test_directed();
        set_vertices(8);
        add_edge(1, 1);                 // self-loop cycle
        add_edge(2, 3);
        add_edge(3, 2);                 // parallel pair cycle
        add_edge(4, 5);                 // path, not a cycle
        add_edge(0, 4);                 // dropped
        add_edge(9, 2);                 // dropped
        finish_graph();
        add_ring(1, 4);
        add_ring(5, 4);
        finish_graph();
        add_edge(1, 1);
        add_edge(1, 1);                 // saturates degree
        send_word(CMD_FINISH, 11'h7FF, 11'h7FF, 1);
        set_vertices(1024);
        add_edge(1024, 1024);
        add_edge(1023, 1024);
        add_edge(2047, 1);
        finish_graph();
        set_vertices(0);
        add_edge(1, 1);
        finish_graph();
        set_vertices(2047);
        add_edge(1024, 1024);
        add_edge(1025, 3);
        finish_graph();
    endtask

    task automatic test_changed_count();
        set_vertices(10);
        add_ring(1, 3);
        add_ring(7, 3);
        set_vertices(5);
        finish_graph();
        set_vertices(1);
        add_edge(1, 1);
        finish_graph();
    endtask

    task automatic test_random_graphs();
        int unsigned n;
        int unsigned roll;
        int unsigned base;
        int unsigned len;
        for (int g = 0; g < 30; g++)
        begin
            n = $urandom_range(1, 40);
            if (g % 15 == 14)
                n = $urandom_range(1000, 1024);
            set_vertices(n);
            rx_stall_on = (g % 4 != 3);
            for (int k = 0; k < 10; k++)
            begin
                roll = $urandom_range(0, 9);
                if (roll < 5)
                begin
                    len = $urandom_range(1, 4);
                    base = $urandom_range(1, n);
                    if (base + len - 1 <= n)
                        add_ring(base, len);
                end
                else if (roll < 8)
                    add_edge($urandom_range(1, n), $urandom_range(1, n));
                else
                    add_edge($urandom_range(0, 2047), $urandom_range(0, 2047));
            end
            finish_graph();
        end
        rx_stall_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (m_tvalid && m_tready)
        begin
            got.cycle_count = m_tdata[10:0];
            got.edges_dropped = m_tdata[11];
            if (expected_reports.size() == 0 || m_tdata[15:12] != 4'h0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected or malformed report word: %h", m_tdata);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report mismatch: expected count %0d drop %0d, got %0d %0d",
                                 want.cycle_count, want.edges_dropped,
                                 got.cycle_count, got.edges_dropped);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rx_stall_on)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 15) == 0) || ($urandom_range(0, 1) == 1);
    end

    initial
    begin
        graph_vertices = VC_RESET;
        clear_graph();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_changed_count();
        test_random_graphs();
        wait_idle();
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("PASS cycle_component_counter");
        else
            $display("FAIL cycle_component_counter");
        $finish;
    end
endmodule

// File: filelist.f
sv/ccc_pkg.sv
sv/ccc_ram.sv
sv/cycle_component_counter.sv
sv/ccc_checker.sv
sim/testbench.sv
